>>> src/threshold_run_pixel_sort_assert.svh
// assertion macros for the threshold run pixel sorter checker
`ifndef THRESHOLD_RUN_PIXEL_SORT_ASSERT_SVH
`define THRESHOLD_RUN_PIXEL_SORT_ASSERT_SVH

// same-cycle implication, held off during reset
`define TRPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("threshold_run_pixel_sort: property violated");

// next-cycle implication, held off during reset
`define TRPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("threshold_run_pixel_sort: property violated");

`endif

>>> src/trps_pkg.sv
// types, constants and the intensity function of the threshold run pixel sorter
package trps_pkg;

    localparam logic [7:0] THRESHOLD_RESET = 8'd30;

    // divide by 3 as multiply by 683 and shift by 11, exact for sums up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    // queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_BELOW,
        CLS_EQUAL,
        CLS_ABOVE
    } cls_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DRAIN_PRE,
        BK_INSERT,
        BK_DRAIN_EOL,
        BK_PASS
    } bk_state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    typedef struct packed {
        pix_t       pix;
        logic [7:0] key;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        cls_t   cls;
        logic   eol;
    } cmd_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } row_ctl_t;

    function automatic logic [7:0] intensity(input pix_t p);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = 10'(p.red) + 10'(p.green) + 10'(p.blue);
        prod = 20'(sum) * 20'(DIV3_MUL);
        return prod[DIV3_SHIFT +: 8];
    endfunction

endpackage

>>> src/trps_front.sv
// front end: threshold register, intensity and classification of each item
module trps_front import trps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       end_of_line,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [7:0] threshold_reg;
    logic [7:0] threshold_next;
    pix_t       pix;
    logic [7:0] key;

    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign pix = '{red: red, green: green, blue: blue, alpha: alpha};
    assign key = intensity(pix);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.ent.pix = pix;
        q_cmd.ent.key = key;
        q_cmd.eol     = end_of_line;
        if (key < threshold_reg)
        begin
            q_cmd.cls = CLS_BELOW;
        end
        else if (key == threshold_reg)
        begin
            q_cmd.cls = CLS_EQUAL;
        end
        else
        begin
            q_cmd.cls = CLS_ABOVE;
        end
    end

endmodule

>>> src/trps_queue.sv
// short command queue between the front end and the run sequencer
module trps_queue import trps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/trps_run_row.sv
// row of run cells kept sorted by intensity, insert in place and shift out at the head
module trps_run_row import trps_pkg::*;
#(
    parameter int MaxRun = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  row_ctl_t                     ctl,
    input  entry_t                       ins_ent,
    output entry_t                       head,
    output logic [$clog2(MaxRun+1)-1:0] count
);

    localparam int CntW = $clog2(MaxRun + 1);

    entry_t          cell_reg  [MaxRun];
    entry_t          cell_next [MaxRun];
    logic [CntW-1:0] len_reg;
    logic [CntW-1:0] len_next;

    // new item goes after every stored item of equal or lower key
    always_comb
    begin
        for (int i = 0; i < MaxRun; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (ctl.pop)
            begin
                if (i < MaxRun - 1)
                begin
                    cell_next[i] = cell_reg[(i < MaxRun - 1) ? i + 1 : i];
                end
            end
            else if (ctl.ins && (CntW'(i) <= len_reg))
            begin
                if ((i > 0) && (cell_reg[(i > 0) ? i - 1 : 0].key > ins_ent.key))
                begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end
                else if ((CntW'(i) == len_reg) || (cell_reg[i].key > ins_ent.key))
                begin
                    cell_next[i] = ins_ent;
                end
            end
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (ctl.pop)
        begin
            len_next = len_reg - 1'b1;
        end
        else if (ctl.ins)
        begin
            len_next = len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign head  = cell_reg[0];
    assign count = len_reg;

endmodule

>>> src/trps_back.sv
// back end: run sequencer, sorted drain and output register
module trps_back import trps_pkg::*;
#(
    parameter int MaxRun = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic       out_end_of_line,
    output logic       last
);

    localparam int CntW = $clog2(MaxRun + 1);

    bk_state_t       state_reg;
    bk_state_t       state_next;
    cmd_t            cmd_reg;
    cmd_t            cmd_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    pix_t            out_pix_reg;
    pix_t            out_pix_next;
    logic            out_last_reg;
    logic            out_last_next;
    logic            out_eol_reg;
    logic            out_eol_next;
    logic            load;
    logic            load_ok;
    row_ctl_t        row_ctl;
    entry_t          head;
    logic [CntW-1:0] count;
    logic            one_left;
    logic            need_flush;

    trps_run_row #(
        .MaxRun (MaxRun)
    ) u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (row_ctl),
        .ins_ent (cmd_reg.ent),
        .head    (head),
        .count   (count)
    );

    assign load_ok    = !out_valid_reg || !out_stall;
    assign one_left   = (count == CntW'(1));
    assign need_flush = (q_cmd.cls != CLS_ABOVE) || (count >= CntW'(MaxRun));

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        q_pop         = 1'b0;
        row_ctl       = '0;
        load          = 1'b0;
        out_pix_next  = out_pix_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if (need_flush && (count != '0))
                    begin
                        state_next = BK_DRAIN_PRE;
                    end
                    else if (q_cmd.cls == CLS_BELOW)
                    begin
                        state_next = BK_PASS;
                    end
                    else
                    begin
                        state_next = BK_INSERT;
                    end
                end
            end
            BK_DRAIN_PRE:
            begin
                if (load_ok)
                begin
                    load          = 1'b1;
                    row_ctl.pop   = 1'b1;
                    out_pix_next  = head.pix;
                    // final result only when nothing follows the flush
                    out_last_next = one_left && (cmd_reg.cls != CLS_BELOW) && !cmd_reg.eol;
                    if (one_left)
                    begin
                        state_next = (cmd_reg.cls == CLS_BELOW) ? BK_PASS : BK_INSERT;
                    end
                end
            end
            BK_INSERT:
            begin
                row_ctl.ins = 1'b1;
                state_next  = cmd_reg.eol ? BK_DRAIN_EOL : BK_IDLE;
            end
            BK_DRAIN_EOL:
            begin
                if (load_ok)
                begin
                    load          = 1'b1;
                    row_ctl.pop   = 1'b1;
                    out_pix_next  = head.pix;
                    out_last_next = one_left;
                    if (one_left)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_PASS:
            begin
                if (load_ok)
                begin
                    load          = 1'b1;
                    out_pix_next  = cmd_reg.ent.pix;
                    out_last_next = 1'b1;
                    state_next    = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_eol_next = load ? (out_last_next && cmd_reg.eol) : out_eol_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
        out_eol_reg  <= out_eol_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_red         = out_pix_reg.red;
    assign out_green       = out_pix_reg.green;
    assign out_blue        = out_pix_reg.blue;
    assign out_alpha       = out_pix_reg.alpha;
    assign out_end_of_line = out_eol_reg;
    assign last            = out_last_reg;

endmodule

>>> src/threshold_run_pixel_sort.sv
// with no run open, a pixel below threshold passes the queue, cmd_reg and output register
// back end: each item is fetched, then inserted or passed, one at a time; a closing run is drained
//   pixel by pixel while the output is not stalled; the run sequencer and its cell row set this
// the input side keeps accepting while the back end drains, up to the 2-item queue
// reset: asynchronous, clears the queue, run length, sequencer and output valid,
//   threshold returns to 30; run cells need no clearing
module threshold_run_pixel_sort import trps_pkg::*;
#(
    parameter int MAX_RUN = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       end_of_line,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic       out_end_of_line,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_head_cmd;

    trps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .end_of_line (end_of_line),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd)
    );

    trps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd)
    );

    trps_back #(
        .MaxRun (MAX_RUN)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_not_empty),
        .q_cmd           (q_head_cmd),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_red         (out_red),
        .out_green       (out_green),
        .out_blue        (out_blue),
        .out_alpha       (out_alpha),
        .out_end_of_line (out_end_of_line),
        .last            (last)
    );

endmodule

>>> src/trps_checker.sv
// port-level checker for the threshold run pixel sorter and its bind
`include "threshold_run_pixel_sort_assert.svh"

module trps_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       end_of_line,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha,
    input logic       out_end_of_line,
    input logic       last
);

    logic [7:0] pend_eol_reg;
    logic [7:0] pend_eol_next;
    logic       eol_in;
    logic       eol_out;

    // row ends accepted but not yet delivered
    assign eol_in  = in_valid && !in_stall && end_of_line;
    assign eol_out = out_valid && !out_stall && out_end_of_line;

    always_comb
    begin
        pend_eol_next = pend_eol_reg;
        if (eol_in && !eol_out)
        begin
            pend_eol_next = pend_eol_reg + 1'b1;
        end
        else if (eol_out && !eol_in && (pend_eol_reg != '0))
        begin
            pend_eol_next = pend_eol_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_eol_reg <= '0;
        end
        else
        begin
            pend_eol_reg <= pend_eol_next;
        end
    end

    `TRPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({out_red, out_green, out_blue, out_alpha, out_end_of_line, last}))
    `TRPS_ASSERT_IMP(a_eol_is_last, clk, rst_n, out_valid && out_end_of_line, last)
    `TRPS_ASSERT_IMP(a_eol_has_source, clk, rst_n, eol_out, pend_eol_reg != 8'd0)

endmodule

bind threshold_run_pixel_sort trps_checker u_trps_checker (.*);
